// ----- src/rgb_rainbow_fade_generator_unit_macros.svh -----
// Assertion helpers for the RTL.
`ifndef RGB_RAINBOW_FADE_GENERATOR_UNIT_MACROS_SVH
`define RGB_RAINBOW_FADE_GENERATOR_UNIT_MACROS_SVH

`ifndef SYNTH
`define RFG_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("rgb fade assertion failed");
`define RFG_ASSERT_ANY(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("rgb fade assertion failed");
`else
`define RFG_ASSERT(label, clk, rst, prop)
`define RFG_ASSERT_ANY(label, clk, prop)
`endif

`endif

// ----- src/rgbfade_pkg.sv -----
package rgbfade_pkg;

   localparam int unsigned PERIOD_W = 16;
   localparam int unsigned LEVEL_W  = 8;

   localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd10;

   localparam logic [1:0] PHASE_SLOW_RG = 2'd0;
   localparam logic [1:0] PHASE_FAST_RG = 2'd1;
   localparam logic [1:0] PHASE_GB      = 2'd2;
   localparam logic [1:0] PHASE_BR      = 2'd3;

   localparam logic [1:0]         SLOW_LAST  = 2'd3;
   localparam logic [LEVEL_W-1:0] LEVEL_MAX  = 8'hFF;
   localparam logic [LEVEL_W-1:0] GREEN_FAST = 8'h04;

   typedef struct packed {
      logic [PERIOD_W-1:0] divider;
      logic [1:0]          phase;
      logic [1:0]          slow;
      logic [LEVEL_W-1:0]  red;
      logic [LEVEL_W-1:0]  green;
      logic [LEVEL_W-1:0]  blue;
   } fade_state_type;

   localparam fade_state_type FADE_START = '{
      divider: '0,
      phase:   PHASE_SLOW_RG,
      slow:    '0,
      red:     LEVEL_MAX,
      green:   '0,
      blue:    '0
   };

endpackage

// ----- src/rgbfade_step.sv -----
module rgbfade_step (
   input  rgbfade_pkg::fade_state_type     cur_state,
   input  logic                            restart,
   input  logic [rgbfade_pkg::PERIOD_W-1:0] period,
   output rgbfade_pkg::fade_state_type     nxt_state
);
   import rgbfade_pkg::*;

   fade_state_type base;
   fade_state_type adv;
   logic [LEVEL_W-1:0] red_dn, red_up, green_dn, green_up, blue_dn, blue_up;

   // restart clears first, then the tick is handled as usual
   assign base = restart ? FADE_START : cur_state;

   assign red_dn   = base.red - 1'b1;
   assign red_up   = base.red + 1'b1;
   assign green_dn = base.green - 1'b1;
   assign green_up = base.green + 1'b1;
   assign blue_dn  = base.blue - 1'b1;
   assign blue_up  = base.blue + 1'b1;

   always_comb begin
      adv = base;
      case (base.phase)
         PHASE_SLOW_RG: begin
            if (base.slow == SLOW_LAST) begin
               adv.slow  = '0;
               adv.red   = red_dn;
               adv.green = green_up;
               if (green_up == GREEN_FAST) adv.phase = PHASE_FAST_RG;
            end else begin
               adv.slow = base.slow + 1'b1;
            end
         end
         PHASE_FAST_RG: begin
            adv.red   = red_dn;
            adv.green = green_up;
            if (green_up == LEVEL_MAX) adv.phase = PHASE_GB;
         end
         PHASE_GB: begin
            adv.green = green_dn;
            adv.blue  = blue_up;
            if (blue_up == LEVEL_MAX) adv.phase = PHASE_BR;
         end
         PHASE_BR: begin
            adv.blue = blue_dn;
            adv.red  = red_up;
            if (red_up == LEVEL_MAX) begin
               adv.phase = PHASE_SLOW_RG;
               adv.slow  = '0;
            end
         end
         default: begin
            adv = base;
         end
      endcase
   end

   always_comb begin
      if (base.divider == period) begin
         nxt_state         = adv;
         nxt_state.divider = '0;
      end else begin
         nxt_state         = base;
         nxt_state.divider = base.divider + 1'b1;
      end
   end

endmodule

// ----- src/rgb_rainbow_fade_generator_unit.sv -----
// The colour of an accepted request is registered and shown on the rsp_ side
// in the next cycle. Throughput: one request per cycle while rsp_ready drains the
// result; the single result register is refilled in the same cycle it is drained.
// Reset: synchronous, active high; fade state returns to red FF, divider, phase
// and slow counter to 0, tick period to 10, no result pending; colour outputs are not reset.
`include "rgb_rainbow_fade_generator_unit_macros.svh"

module rgb_rainbow_fade_generator_unit (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic                              req_restart,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [rgbfade_pkg::LEVEL_W-1:0]   rsp_red_level,
   output logic [rgbfade_pkg::LEVEL_W-1:0]   rsp_green_level,
   output logic [rgbfade_pkg::LEVEL_W-1:0]   rsp_blue_level,
   input  logic                              csr_write_enable,
   input  logic [rgbfade_pkg::PERIOD_W-1:0]  csr_write_data
);
   import rgbfade_pkg::*;

   logic [PERIOD_W-1:0] tick_period_ff, tick_period_in;
   fade_state_type      state_ff, state_in, step_state;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [LEVEL_W-1:0]  red_ff, red_in, green_ff, green_in, blue_ff, blue_in;
   logic                req_accept;
   logic [LEVEL_W:0]    colour_sum;

   rgbfade_step u_step (
      .cur_state (state_ff),
      .restart   (req_restart),
      .period    (tick_period_ff),
      .nxt_state (step_state)
   );

   assign req_ready  = !rsp_valid_ff || rsp_ready;
   assign req_accept = req_valid && req_ready;

   always_comb begin
      tick_period_in = csr_write_enable ? csr_write_data : tick_period_ff;
      state_in       = req_accept ? step_state : state_ff;
      rsp_valid_in   = req_accept || (rsp_valid_ff && !rsp_ready);
      red_in         = req_accept ? step_state.red   : red_ff;
      green_in       = req_accept ? step_state.green : green_ff;
      blue_in        = req_accept ? step_state.blue  : blue_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_period_ff <= PERIOD_RESET;
         state_ff       <= FADE_START;
         rsp_valid_ff   <= 1'b0;
      end else begin
         tick_period_ff <= tick_period_in;
         state_ff       <= state_in;
         rsp_valid_ff   <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      red_ff   <= red_in;
      green_ff <= green_in;
      blue_ff  <= blue_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_red_level   = red_ff;
   assign rsp_green_level = green_ff;
   assign rsp_blue_level  = blue_ff;

   // each fade advance trades one unit between two channels, so the sum stays FF
   assign colour_sum = {1'b0, state_ff.red} + {1'b0, state_ff.green} + {1'b0, state_ff.blue};

   `RFG_ASSERT(a_colour_sum, clock, reset, colour_sum == {1'b0, LEVEL_MAX})
   `RFG_ASSERT(a_accept_gives_rsp, clock, reset, req_accept |=> rsp_valid)
   `RFG_ASSERT(a_divider_wrap, clock, reset, (req_accept && !req_restart && state_ff.divider == tick_period_ff) |=> state_ff.divider == '0)
   `RFG_ASSERT(a_rsp_matches_state, clock, reset, req_accept |=> (rsp_red_level == state_ff.red && rsp_blue_level == state_ff.blue))
   `RFG_ASSERT_ANY(a_reset_empty, clock, reset |=> !rsp_valid)

endmodule

// ----- tb/sv/tb.sv -----
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import rgbfade_pkg::*;

   typedef struct packed {
      logic [LEVEL_W-1:0] red;
      logic [LEVEL_W-1:0] green;
      logic [LEVEL_W-1:0] blue;
   } color_type;

   logic                clock;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_ready;
   logic                req_restart = 1'b0;
   logic                rsp_valid;
   logic                rsp_ready = 1'b0;
   logic [LEVEL_W-1:0]  rsp_red_level;
   logic [LEVEL_W-1:0]  rsp_green_level;
   logic [LEVEL_W-1:0]  rsp_blue_level;
   logic                csr_write_enable = 1'b0;
   logic [PERIOD_W-1:0] csr_write_data = '0;

   // pending requests (restart flag) and colors still owed by the block
   logic      tick_queue[$];
   color_type expected_colors[$];

   int send_idle_pct = 0;
   int recv_idle_pct = 0;
   int fail_count = 0;
   bit hold_go = 1'b0;
   bit hold_done = 1'b0;
   int hold_left = 0;

   // fade predictor state
   logic [PERIOD_W-1:0] model_period = PERIOD_RESET;
   logic [PERIOD_W-1:0] div_count = '0;
   logic [1:0]          fade_phase = PHASE_SLOW_RG;
   logic [1:0]          slow_count = '0;
   color_type           level = '{red: LEVEL_MAX, green: '0, blue: '0};

   rgb_rainbow_fade_generator_unit uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_restart      (req_restart),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_red_level    (rsp_red_level),
      .rsp_green_level  (rsp_green_level),
      .rsp_blue_level   (rsp_blue_level),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   function automatic void advance_fade(input logic restart);
      if (restart) begin
         div_count  = '0;
         fade_phase = PHASE_SLOW_RG;
         slow_count = '0;
         level      = '{red: LEVEL_MAX, green: '0, blue: '0};
      end
      if (div_count == model_period) begin
         div_count = '0;
         case (fade_phase)
            PHASE_SLOW_RG: begin
               if (slow_count == SLOW_LAST) begin
                  slow_count  = '0;
                  level.red   = level.red - 8'd1;
                  level.green = level.green + 8'd1;
                  if (level.green == GREEN_FAST)
                     fade_phase = PHASE_FAST_RG;
               end else begin
                  slow_count = slow_count + 2'd1;
               end
            end
            PHASE_FAST_RG: begin
               level.red   = level.red - 8'd1;
               level.green = level.green + 8'd1;
               if (level.green == LEVEL_MAX)
                  fade_phase = PHASE_GB;
            end
            PHASE_GB: begin
               level.green = level.green - 8'd1;
               level.blue  = level.blue + 8'd1;
               if (level.blue == LEVEL_MAX)
                  fade_phase = PHASE_BR;
            end
            default: begin
               level.blue = level.blue - 8'd1;
               level.red  = level.red + 8'd1;
               if (level.red == LEVEL_MAX) begin
                  fade_phase = PHASE_SLOW_RG;
                  slow_count = '0;
               end
            end
         endcase
      end else begin
         div_count = div_count + 16'd1;
      end
      expected_colors.push_back(level);
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid   <= 1'b0;
         req_restart <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (tick_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
            req_valid   <= 1'b1;
            req_restart <= tick_queue.pop_front();
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   // response sink, with one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
         hold_left <= 0;
      end else if (hold_go && !hold_done) begin
         hold_done <= 1'b1;
         hold_left <= 300;
         rsp_ready <= 1'b0;
      end else if (hold_left > 0) begin
         hold_left <= hold_left - 1;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= recv_idle_pct);
      end
   end

   // monitor: check the result first, then predict the request taken this edge
   always @(posedge clock) begin
      color_type got;
      color_type want;
      if (!reset) begin
         if (rsp_valid && rsp_ready) begin
            got = '{red: rsp_red_level, green: rsp_green_level, blue: rsp_blue_level};
            if (expected_colors.size() == 0) begin
               $error("color result with no request outstanding: %h", got);
               fail_count++;
            end else begin
               want = expected_colors.pop_front();
               if (got.red !== want.red) begin
                  $error("red_level: expected %h, got %h", want.red, got.red);
                  fail_count++;
               end
               if (got.green !== want.green) begin
                  $error("green_level: expected %h, got %h", want.green, got.green);
                  fail_count++;
               end
               if (got.blue !== want.blue) begin
                  $error("blue_level: expected %h, got %h", want.blue, got.blue);
                  fail_count++;
               end
            end
         end
         if (req_valid && req_ready)
            advance_fade(req_restart);
      end
   end

   task automatic wait_idle();
      @(negedge clock);
      while (tick_queue.size() != 0 || req_valid || expected_colors.size() != 0)
         @(negedge clock);
      repeat (2) @(negedge clock);
   endtask

   task automatic write_period(input logic [PERIOD_W-1:0] value);
      wait_idle();
      @(posedge clock);
      csr_write_data   <= value;
      csr_write_enable <= 1'b1;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      model_period = value;
      @(negedge clock);
   endtask

   task automatic queue_ticks(input int count, input int restart_odds);
      for (int i = 0; i < count; i++)
         tick_queue.push_back(restart_odds > 0 && $urandom_range(restart_odds - 1) == 0);
   endtask

   task automatic set_idle(input int send_pct, input int recv_pct);
      send_idle_pct = send_pct;
      recv_idle_pct = recv_pct;
   endtask

   initial begin
      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // default period: one advance at tick 11, then restart
      set_idle(36, 71);
      queue_ticks(11, 0);
      tick_queue.push_back(1'b1);
      queue_ticks(2, 0);

      // period 0: divider stays above it until the restart, then every tick advances and slow start shows a color step
      write_period(16'd0);
      queue_ticks(6, 0);
      tick_queue.push_back(1'b1);
      queue_ticks(3, 0);

      write_period(16'hFFFF);
      queue_ticks(5, 0);
      tick_queue.push_back(1'b1);

      // slow start, fast red to green and well into green to blue
      write_period(16'd0);
      set_idle(71, 36);
      queue_ticks(40, 16);
      tick_queue.push_back(1'b1);
      queue_ticks(440, 0);
      wait_idle();

      // no idling; long receiver hold-off while requests keep coming
      set_idle(0, 0);
      write_period(16'($urandom_range(2, 9)));
      queue_ticks(60, 24);
      hold_go = 1'b1;

      // period lowered below the running count: divider keeps counting up
      write_period(16'd20);
      tick_queue.push_back(1'b1);
      queue_ticks(10, 0);
      write_period(16'd3);
      queue_ticks(30, 0);
      tick_queue.push_back(1'b1);
      queue_ticks(5, 0);

      write_period(16'd1);
      queue_ticks(40, 20);

      wait_idle();
      repeat (4) @(negedge clock);
      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

endmodule

// ----- rgb_rainbow_fade_generator_unit.f -----
+incdir+src
src/rgbfade_pkg.sv
src/rgbfade_step.sv
src/rgb_rainbow_fade_generator_unit.sv
tb/sv/tb.sv
